>>> src/gcs_pkg.sv
`timescale 1ns / 1ps

package gcs_pkg;

    // Grapheme break classes.
    localparam logic [3:0] GC_OTHER   = 4'd0;
    localparam logic [3:0] GC_CR      = 4'd1;
    localparam logic [3:0] GC_LF      = 4'd2;
    localparam logic [3:0] GC_CONTROL = 4'd3;
    localparam logic [3:0] GC_EXTEND  = 4'd4;
    localparam logic [3:0] GC_ZWJ     = 4'd5;
    localparam logic [3:0] GC_RI      = 4'd6;
    localparam logic [3:0] GC_PREPEND = 4'd7;
    localparam logic [3:0] GC_SPACING = 4'd8;
    localparam logic [3:0] GC_L       = 4'd9;
    localparam logic [3:0] GC_V       = 4'd10;
    localparam logic [3:0] GC_T       = 4'd11;
    localparam logic [3:0] GC_LV      = 4'd12;
    localparam logic [3:0] GC_LVT     = 4'd13;

    // Indic conjunct break classes.
    localparam logic [1:0] INCB_NONE      = 2'd0;
    localparam logic [1:0] INCB_CONSONANT = 2'd1;
    localparam logic [1:0] INCB_EXTEND    = 2'd2;
    localparam logic [1:0] INCB_LINKER    = 2'd3;

    typedef struct packed {
        logic        final_cluster;
        logic [31:0] cluster_number;
        logic [31:0] scalar_count;
        logic [31:0] first_scalar;
        logic [31:0] span_length;
        logic [31:0] span_start;
    } gcs_result_t;

endpackage

>>> src/gcs_out_queue.sv
`timescale 1ns / 1ps

module gcs_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         wr_cnt,
    input  gcs_pkg::gcs_result_t wr_a,
    input  gcs_pkg::gcs_result_t wr_b,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output gcs_pkg::gcs_result_t out_data
);
    import gcs_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    gcs_result_t   q_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[rd_ptr_reg];
    // Room for the two clusters a single scalar can close.
    assign room      = (cnt_reg <= CW'(DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = AW'(wr_ptr_reg + AW'(wr_cnt));
        rd_ptr_next = pop ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = CW'(cnt_reg + CW'(wr_cnt) - CW'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= wr_a;
        end
        if (wr_cnt == 2'd2)
        begin
            q_reg[AW'(wr_ptr_reg + 1'b1)] <= wr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> src/grapheme_cluster_segmenter.sv
`timescale 1ns / 1ps

// Extended grapheme cluster segmenter. One Unicode scalar is taken per
// cycle with its break properties already looked up; the scalar passes an
// input register, then the boundary rules and span tracking run and the
// closed clusters land in a four-entry result queue that drives the output
// port. A scalar closes zero, one or two clusters; the output port delivers
// one cluster per cycle while m_tready is high, so a scalar that both breaks
// and ends the text takes two output transfers, and input is held off only
// while the queue cannot take two more clusters. join_conjuncts (reset 1)
// enables the Indic conjunct join and must be written only while the block
// is idle.
module grapheme_cluster_segmenter (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // source_offset [31:0], source_length [63:32]
    input  logic [63:0]  s_tdata,
    // grapheme_class [3:0], conjunct_class [5:4], ext_pictographic [6]
    input  logic [6:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // span_start [31:0], span_length [63:32], first_scalar [95:64],
    // scalar_count [127:96], cluster_number [159:128]
    output logic [159:0] m_tdata,
    output logic         m_tlast
);
    import gcs_pkg::*;

    logic        join_reg;

    // Input register.
    logic        in_vld_reg;
    logic [3:0]  cls_reg;
    logic [1:0]  incb_reg;
    logic        pict_reg;
    logic [31:0] off_reg;
    logic [31:0] end_reg;
    logic        last_reg;
    logic [32:0] end_sum;
    logic        s_fire, adv, room;

    // Segmentation state.
    logic        open_reg, open_next;
    logic [3:0]  left_reg, left_next;
    logic        ri_reg, ri_next;
    logic        ps_reg, ps_next;
    logic        zr_reg, zr_next;
    logic        cons_reg, cons_next;
    logic        link_reg, link_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] idx_reg, idx_next;
    logic [31:0] emitted_reg, emitted_next;

    logic        ri_eff, ps_eff, zr_eff, cons_eff, link_eff;
    logic        rule_break, brk;
    logic        left_ctl, right_ctl;
    logic [31:0] emitted_mid;
    logic [1:0]  wr_cnt;
    gcs_result_t res_brk, res_fin, wr_a, q_out;

    assign s_fire  = s_tvalid && s_tready;
    assign adv     = in_vld_reg && room;
    assign s_tready = !in_vld_reg || room;
    assign end_sum = {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[63:32]};

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cls_reg  <= s_tuser[3:0];
            incb_reg <= s_tuser[5:4];
            pict_reg <= s_tuser[6];
            off_reg  <= s_tdata[31:0];
            end_reg  <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
            last_reg <= s_tlast;
        end
    end

    // Tracking bits restart when a scalar opens a new text.
    assign ri_eff   = open_reg && ri_reg;
    assign ps_eff   = open_reg && ps_reg;
    assign zr_eff   = open_reg && zr_reg;
    assign cons_eff = open_reg && cons_reg;
    assign link_eff = open_reg && link_reg;

    assign left_ctl  = (left_reg == GC_CR) || (left_reg == GC_LF) || (left_reg == GC_CONTROL);
    assign right_ctl = (cls_reg == GC_CR) || (cls_reg == GC_LF) || (cls_reg == GC_CONTROL);

    always_comb
    begin
        priority if (left_reg == GC_CR && cls_reg == GC_LF)
            rule_break = 1'b0;
        else if (left_ctl || right_ctl)
            rule_break = 1'b1;
        else if (left_reg == GC_L && (cls_reg == GC_L || cls_reg == GC_V ||
                                      cls_reg == GC_LV || cls_reg == GC_LVT))
            rule_break = 1'b0;
        else if ((left_reg == GC_LV || left_reg == GC_V) &&
                 (cls_reg == GC_V || cls_reg == GC_T))
            rule_break = 1'b0;
        else if ((left_reg == GC_LVT || left_reg == GC_T) && cls_reg == GC_T)
            rule_break = 1'b0;
        else if (cls_reg == GC_EXTEND || cls_reg == GC_ZWJ || cls_reg == GC_SPACING ||
                 left_reg == GC_PREPEND)
            rule_break = 1'b0;
        else if (join_reg && incb_reg == INCB_CONSONANT && cons_reg && link_reg)
            rule_break = 1'b0;
        else if (pict_reg && zr_reg)
            rule_break = 1'b0;
        else if (left_reg == GC_RI && cls_reg == GC_RI && ri_reg)
            rule_break = 1'b0;
        else
            rule_break = 1'b1;
    end

    assign brk = open_reg && rule_break;

    always_comb
    begin
        open_next    = open_reg;
        left_next    = left_reg;
        ri_next      = ri_reg;
        ps_next      = ps_reg;
        zr_next      = zr_reg;
        cons_next    = cons_reg;
        link_next    = link_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        first_next   = first_reg;
        idx_next     = idx_reg;
        emitted_next = emitted_reg;
        emitted_mid  = emitted_reg;
        wr_cnt       = 2'd0;

        if (adv)
        begin
            if (!open_reg)
            begin
                first_next  = '0;
                lo_next     = off_reg;
                hi_next     = end_reg;
                emitted_mid = '0;
            end
            else if (brk)
            begin
                first_next  = idx_reg;
                lo_next     = off_reg;
                hi_next     = end_reg;
                emitted_mid = emitted_reg + 32'd1;
            end
            else
            begin
                lo_next = (off_reg < lo_reg) ? off_reg : lo_reg;
                hi_next = (end_reg > hi_reg) ? end_reg : hi_reg;
            end

            idx_next  = (open_reg ? idx_reg : 32'd0) + 32'd1;
            left_next = cls_reg;
            ri_next   = (cls_reg == GC_RI) ? !ri_eff : 1'b0;

            priority if (pict_reg)
            begin
                ps_next = 1'b1;
                zr_next = 1'b0;
            end
            else if (cls_reg == GC_EXTEND && ps_eff)
            begin
                ps_next = 1'b1;
                zr_next = 1'b0;
            end
            else if (cls_reg == GC_ZWJ)
            begin
                ps_next = 1'b0;
                zr_next = ps_eff;
            end
            else
            begin
                ps_next = 1'b0;
                zr_next = 1'b0;
            end

            unique case (incb_reg)
                INCB_CONSONANT:
                begin
                    cons_next = 1'b1;
                    link_next = 1'b0;
                end
                INCB_EXTEND:
                begin
                    cons_next = cons_eff;
                    link_next = link_eff;
                end
                INCB_LINKER:
                begin
                    cons_next = cons_eff;
                    link_next = link_eff || cons_eff;
                end
                default:
                begin
                    cons_next = 1'b0;
                    link_next = 1'b0;
                end
            endcase

            emitted_next = emitted_mid + (last_reg ? 32'd1 : 32'd0);
            open_next    = !last_reg;
            wr_cnt       = {1'b0, brk} + {1'b0, last_reg};
        end
    end

    always_comb
    begin
        res_brk.span_start     = lo_reg;
        res_brk.span_length    = hi_reg - lo_reg;
        res_brk.first_scalar   = first_reg;
        res_brk.scalar_count   = idx_reg - first_reg;
        res_brk.cluster_number = emitted_reg;
        res_brk.final_cluster  = 1'b0;

        // The final cluster reports the state as it stands after this scalar.
        res_fin.span_start     = lo_next;
        res_fin.span_length    = hi_next - lo_next;
        res_fin.first_scalar   = first_next;
        res_fin.scalar_count   = idx_next - first_next;
        res_fin.cluster_number = emitted_mid;
        res_fin.final_cluster  = 1'b1;

        wr_a = brk ? res_brk : res_fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            join_reg    <= 1'b1;
            in_vld_reg  <= 1'b0;
            open_reg    <= 1'b0;
            left_reg    <= GC_OTHER;
            ri_reg      <= 1'b0;
            ps_reg      <= 1'b0;
            zr_reg      <= 1'b0;
            cons_reg    <= 1'b0;
            link_reg    <= 1'b0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            first_reg   <= '0;
            idx_reg     <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                join_reg <= cfg_wdata;
            end
            if (s_fire)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_vld_reg <= 1'b0;
            end
            open_reg    <= open_next;
            left_reg    <= left_next;
            ri_reg      <= ri_next;
            ps_reg      <= ps_next;
            zr_reg      <= zr_next;
            cons_reg    <= cons_next;
            link_reg    <= link_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            first_reg   <= first_next;
            idx_reg     <= idx_next;
            emitted_reg <= emitted_next;
        end
    end

    gcs_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_cnt    (wr_cnt),
        .wr_a      (wr_a),
        .wr_b      (res_fin),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_out)
    );

    assign m_tdata = {q_out.cluster_number, q_out.scalar_count, q_out.first_scalar,
                      q_out.span_length, q_out.span_start};
    assign m_tlast = q_out.final_cluster;

endmodule

>>> src/gcs_checker.sv
`timescale 1ns / 1ps

module gcs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic         m_tlast
);
    logic        seen_reg;
    logic        prev_last_reg;
    logic [31:0] prev_num_reg;
    logic        m_fire;

    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_last_reg <= 1'b1;
            prev_num_reg  <= '0;
        end
        else if (m_fire)
        begin
            seen_reg      <= 1'b1;
            prev_last_reg <= m_tlast;
            prev_num_reg  <= m_tdata[159:128];
        end
    end

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Input is held off only while results wait to be taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // Cluster numbers run on within a text and restart after a final cluster.
    a_numbering: assert property (@(posedge clk) disable iff (!rst_n)
        m_fire && seen_reg |->
            m_tdata[159:128] == (prev_last_reg ? 32'd0 : prev_num_reg + 32'd1))
        else $error("cluster number out of sequence");

    // The first cluster of a text starts at scalar zero.
    a_text_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_fire && prev_last_reg |-> m_tdata[95:64] == 32'd0)
        else $error("first cluster of a text does not start at scalar zero");

endmodule

bind grapheme_cluster_segmenter gcs_checker u_gcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> verif/tb_grapheme_cluster_segmenter.sv
`timescale 1ns / 1ps

module tb_grapheme_cluster_segmenter;

    import gcs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 50;

    typedef struct {
        logic [3:0]  cls;
        logic [1:0]  incb;
        bit          pict;
        logic [31:0] off;
        logic [31:0] len;
        bit          tail;
    } scalar_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // source_offset [31:0], source_length [63:32]
    logic [63:0]  s_tdata = '0;
    // grapheme_class [3:0], conjunct_class [5:4], ext_pictographic [6]
    logic [6:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // span_start [31:0], span_length [63:32], first_scalar [95:64],
    // scalar_count [127:96], cluster_number [159:128]
    logic [159:0] m_tdata;
    logic         m_tlast;

    grapheme_cluster_segmenter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 clk = ~clk;

    // Segmenter state as predicted by the testbench.
    bit          join_on = 1'b1;
    bit          text_open = 1'b0;
    logic [3:0]  prev_class = GC_OTHER;
    bit          ri_odd = 1'b0;
    bit          pict_run = 1'b0;
    bit          zwj_armed = 1'b0;
    bit          conj_cons = 1'b0;
    bit          conj_link = 1'b0;
    logic [31:0] cl_lo = '0;
    logic [31:0] cl_hi = '0;
    logic [31:0] cl_first = '0;
    logic [31:0] scalar_no = '0;
    logic [31:0] cluster_no = '0;

    gcs_result_t expected_clusters[$];
    scalar_t     text_buf[$];
    logic [31:0] src_pos = '0;
    int          scalars_sent = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    int          hold_request = 0;
    int          rx_wait = 0;
    gcs_result_t want;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            return 0;
        if (pick < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val, input logic [31:0] idx);
        if (got !== exp_val)
            report_error($sformatf("cluster %0d %s: got %h, expected %h",
                                   idx, name, got, exp_val));
    endtask

    function automatic bit breaks_before(input scalar_t s);
        if (prev_class == GC_CR && s.cls == GC_LF)
            return 1'b0;
        if (prev_class inside {GC_CR, GC_LF, GC_CONTROL} ||
            s.cls inside {GC_CR, GC_LF, GC_CONTROL})
            return 1'b1;
        if (prev_class == GC_L && s.cls inside {GC_L, GC_V, GC_LV, GC_LVT})
            return 1'b0;
        if (prev_class inside {GC_LV, GC_V} && s.cls inside {GC_V, GC_T})
            return 1'b0;
        if (prev_class inside {GC_LVT, GC_T} && s.cls == GC_T)
            return 1'b0;
        if (s.cls inside {GC_EXTEND, GC_ZWJ, GC_SPACING} || prev_class == GC_PREPEND)
            return 1'b0;
        if (join_on && s.incb == INCB_CONSONANT && conj_cons && conj_link)
            return 1'b0;
        if (s.pict && zwj_armed)
            return 1'b0;
        if (prev_class == GC_RI && s.cls == GC_RI && ri_odd)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void close_cluster(input bit fin);
        gcs_result_t r;
        r.span_start     = cl_lo;
        r.span_length    = cl_hi - cl_lo;
        r.first_scalar   = cl_first;
        r.scalar_count   = scalar_no - cl_first;
        r.cluster_number = cluster_no;
        r.final_cluster  = fin;
        expected_clusters.push_back(r);
        cluster_no++;
    endfunction

    function automatic void predict_clusters(input scalar_t s);
        logic [32:0] sum;
        logic [31:0] src_end;
        sum = {1'b0, s.off} + {1'b0, s.len};
        src_end = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (!text_open) begin
            text_open = 1'b1;
            ri_odd = 1'b0;
            pict_run = 1'b0;
            zwj_armed = 1'b0;
            conj_cons = 1'b0;
            conj_link = 1'b0;
            scalar_no = '0;
            cluster_no = '0;
            cl_first = '0;
            cl_lo = s.off;
            cl_hi = src_end;
        end else if (breaks_before(s)) begin
            close_cluster(1'b0);
            cl_first = scalar_no;
            cl_lo = s.off;
            cl_hi = src_end;
        end else begin
            if (s.off < cl_lo)
                cl_lo = s.off;
            if (src_end > cl_hi)
                cl_hi = src_end;
        end

        ri_odd = (s.cls == GC_RI) ? !ri_odd : 1'b0;
        if (s.pict) begin
            pict_run = 1'b1;
            zwj_armed = 1'b0;
        end else if (s.cls == GC_EXTEND && pict_run) begin
            zwj_armed = 1'b0;
        end else if (s.cls == GC_ZWJ) begin
            zwj_armed = pict_run;
            pict_run = 1'b0;
        end else begin
            pict_run = 1'b0;
            zwj_armed = 1'b0;
        end
        case (s.incb)
            INCB_CONSONANT: begin
                conj_cons = 1'b1;
                conj_link = 1'b0;
            end
            INCB_EXTEND: ;
            INCB_LINKER: conj_link = conj_link || conj_cons;
            default: begin
                conj_cons = 1'b0;
                conj_link = 1'b0;
            end
        endcase
        prev_class = s.cls;
        scalar_no++;

        if (s.tail) begin
            close_cluster(1'b1);
            text_open = 1'b0;
        end
    endfunction

    // Every call starts right after a rising edge, so s_tvalid gets a single
    // assignment per time step.
    task automatic send_scalar(input scalar_t s);
        int gap;
        gap = tx_idle ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.len, s.off};
        s_tuser  <= {s.pict, s.incb, s.cls};
        s_tlast  <= s.tail;
        do
            @(posedge clk);
        while (!s_tready);
        predict_clusters(s);
        scalars_sent++;
    endtask

    function automatic scalar_t make_scalar(input logic [3:0] cls, input logic [1:0] incb,
                                            input bit pict, input logic [31:0] off,
                                            input logic [31:0] len, input bit tail);
        scalar_t s;
        s.cls = cls;
        s.incb = incb;
        s.pict = pict;
        s.off = off;
        s.len = len;
        s.tail = tail;
        return s;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_clusters.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_join(input bit value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        join_on = value;
        cfg_we <= 1'b0;
    endtask

    // Offsets mostly run on contiguously through the text; a few jump anywhere
    // so that every bit moves and the source end saturates now and then.
    function automatic void queue_scalar(input logic [3:0] cls, input logic [1:0] incb,
                                         input bit pict);
        scalar_t s;
        s.cls = cls;
        s.incb = incb;
        s.pict = pict;
        s.tail = 1'b0;
        case ($urandom_range(0, 15))
            0: begin
                s.off = $urandom;
                s.len = $urandom;
            end
            1: begin
                s.off = $urandom;
                s.len = $urandom_range(0, 4);
            end
            default: begin
                s.off = src_pos;
                s.len = $urandom_range(1, 4);
            end
        endcase
        src_pos = s.off + s.len;
        text_buf.push_back(s);
    endfunction

    function automatic void add_segment();
        logic [3:0] marks[3] = '{GC_EXTEND, GC_SPACING, GC_ZWJ};
        logic [3:0] jamo[5]  = '{GC_L, GC_V, GC_T, GC_LV, GC_LVT};
        case ($urandom_range(0, 7))
            0: begin
                queue_scalar(GC_OTHER, INCB_NONE, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 3))
                    queue_scalar(marks[2'($urandom_range(0, 2))], INCB_NONE, 1'b0);
            end
            1: repeat ($urandom_range(1, 4))
                queue_scalar(jamo[3'($urandom_range(0, 4))], INCB_NONE, 1'b0);
            2: begin
                queue_scalar(GC_OTHER, INCB_NONE, 1'b1);
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1))
                        queue_scalar(GC_EXTEND, INCB_NONE, 1'b0);
                    queue_scalar(GC_ZWJ, INCB_NONE, 1'b0);
                    queue_scalar(GC_OTHER, INCB_NONE, $urandom_range(0, 3) != 0);
                end
            end
            3: repeat ($urandom_range(1, 5))
                queue_scalar(GC_RI, INCB_NONE, 1'b0);
            4: begin
                queue_scalar(GC_OTHER, INCB_CONSONANT, 1'b0);
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 2))
                        0: queue_scalar(GC_EXTEND, INCB_LINKER, 1'b0);
                        1: queue_scalar(GC_EXTEND, INCB_EXTEND, 1'b0);
                        default: queue_scalar(GC_ZWJ, INCB_EXTEND, 1'b0);
                    endcase
                    queue_scalar(GC_OTHER, INCB_CONSONANT, 1'b0);
                end
            end
            5: case ($urandom_range(0, 3))
                0: begin
                    queue_scalar(GC_CR, INCB_NONE, 1'b0);
                    queue_scalar(GC_LF, INCB_NONE, 1'b0);
                end
                1: queue_scalar(GC_CR, INCB_NONE, 1'b0);
                2: queue_scalar(GC_LF, INCB_NONE, 1'b0);
                default: queue_scalar(GC_CONTROL, INCB_NONE, 1'b0);
            endcase
            6: begin
                queue_scalar(GC_PREPEND, INCB_NONE, 1'b0);
                queue_scalar(GC_OTHER, INCB_NONE, 1'b0);
            end
            default: repeat ($urandom_range(1, 3))
                queue_scalar(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)));
        endcase
    endfunction

    task automatic send_random_text();
        text_buf.delete();
        if ($urandom_range(0, 9) == 0)
            src_pos = 32'hFFFF_FFFF - $urandom_range(0, 12);
        repeat ($urandom_range(1, 4)) add_segment();
        text_buf[text_buf.size() - 1].tail = 1'b1;
        foreach (text_buf[i])
            send_scalar(text_buf[i]);
    endtask

    task automatic send_texts(input int count);
        int stop_at;
        stop_at = scalars_sent + count;
        while (scalars_sent < stop_at)
            send_random_text();
    endtask

    task automatic test_directed_rules();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        // A text of one scalar gives a lone final cluster.
        send_scalar(make_scalar(GC_OTHER, INCB_NONE, 0, 32'h0, 32'h0, 1));
        send_scalar(make_scalar(GC_CR, INCB_NONE, 0, 32'd10, 32'd1, 0));
        send_scalar(make_scalar(GC_LF, INCB_NONE, 0, 32'd11, 32'd1, 0));
        send_scalar(make_scalar(GC_CONTROL, INCB_NONE, 0, 32'd12, 32'd1, 0));
        send_scalar(make_scalar(GC_L, INCB_NONE, 0, 32'd13, 32'd3, 0));
        send_scalar(make_scalar(GC_V, INCB_NONE, 0, 32'd16, 32'd3, 0));
        send_scalar(make_scalar(GC_T, INCB_NONE, 0, 32'd19, 32'd3, 0));
        send_scalar(make_scalar(GC_LV, INCB_NONE, 0, 32'd22, 32'd3, 0));
        send_scalar(make_scalar(GC_T, INCB_NONE, 0, 32'd25, 32'd3, 0));
        send_scalar(make_scalar(GC_LVT, INCB_NONE, 0, 32'd28, 32'd3, 0));
        send_scalar(make_scalar(GC_T, INCB_NONE, 0, 32'd31, 32'd3, 0));
        send_scalar(make_scalar(GC_PREPEND, INCB_NONE, 0, 32'd34, 32'd2, 0));
        send_scalar(make_scalar(GC_OTHER, INCB_NONE, 1, 32'd36, 32'd4, 0));
        // The extend reaches back below the span start of its cluster.
        send_scalar(make_scalar(GC_EXTEND, INCB_NONE, 0, 32'd5, 32'd2, 0));
        send_scalar(make_scalar(GC_ZWJ, INCB_NONE, 0, 32'd40, 32'd3, 0));
        send_scalar(make_scalar(GC_OTHER, INCB_NONE, 1, 32'd43, 32'd4, 0));
        send_scalar(make_scalar(GC_RI, INCB_NONE, 0, 32'd47, 32'd4, 0));
        send_scalar(make_scalar(GC_RI, INCB_NONE, 0, 32'd51, 32'd4, 0));
        send_scalar(make_scalar(GC_RI, INCB_NONE, 0, 32'd55, 32'd4, 0));
        send_scalar(make_scalar(GC_OTHER, INCB_CONSONANT, 0, 32'd59, 32'd3, 0));
        send_scalar(make_scalar(GC_EXTEND, INCB_LINKER, 0, 32'd62, 32'd3, 0));
        send_scalar(make_scalar(GC_OTHER, INCB_CONSONANT, 0, 32'd65, 32'd3, 0));
        send_scalar(make_scalar(GC_SPACING, INCB_NONE, 0, 32'd68, 32'd3, 0));
        // Undefined class, saturating end, and a break on the last scalar.
        send_scalar(make_scalar(4'd15, INCB_NONE, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1));
        drain();
    endtask

    task automatic test_conjunct_disabled();
        write_join(1'b0);
        send_scalar(make_scalar(GC_OTHER, INCB_CONSONANT, 0, 32'd100, 32'd3, 0));
        send_scalar(make_scalar(GC_EXTEND, INCB_LINKER, 0, 32'd103, 32'd3, 0));
        send_scalar(make_scalar(GC_OTHER, INCB_CONSONANT, 0, 32'd106, 32'd3, 1));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_texts(80);
        drain();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // scalars back to back, so the result queue fills and input stalls.
    task automatic test_output_backpressure();
        write_join(1'b1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_request = 150;
        send_texts(40);
        drain();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            write_join(1'($urandom_range(0, 1)));
            tx_idle = (phase != 0);
            rx_idle = (phase != 0);
            send_texts(65);
        end
        drain();
    endtask

    always @(posedge clk) begin
        if (hold_request != 0) begin
            rx_wait = hold_request;
            hold_request = 0;
        end else if (rx_wait == 0 && rx_idle && $urandom_range(0, 2) == 0) begin
            rx_wait = idle_len();
        end
        if (rx_wait != 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_clusters.size() == 0) begin
                report_error($sformatf("unexpected cluster %h last %b", m_tdata, m_tlast));
            end else begin
                want = expected_clusters.pop_front();
                check_field("span_start", m_tdata[31:0], want.span_start,
                            want.cluster_number);
                check_field("span_length", m_tdata[63:32], want.span_length,
                            want.cluster_number);
                check_field("first_scalar", m_tdata[95:64], want.first_scalar,
                            want.cluster_number);
                check_field("scalar_count", m_tdata[127:96], want.scalar_count,
                            want.cluster_number);
                check_field("cluster_number", m_tdata[159:128], want.cluster_number,
                            want.cluster_number);
                check_field("final_cluster", {31'd0, m_tlast}, {31'd0, want.final_cluster},
                            want.cluster_number);
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_rules();
        test_conjunct_disabled();
        test_output_backpressure();
        test_random_traffic();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
